@@ hw/rtl/ier_pkg.sv @@
// ----------------------------------------------------------------------------
// ier_pkg
// Shared types, constants and helpers for the ICMP echo responder.
// ----------------------------------------------------------------------------
package ier_pkg;

  localparam int MAX_HEADER_WORDS = 41;
  localparam int DATA_W           = 16;
  localparam int CNT_W            = 6;
  localparam int AW               = $clog2(MAX_HEADER_WORDS);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [AW-1:0]     addr_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam cnt_t MAX_N         = cnt_t'(MAX_HEADER_WORDS);
  localparam cnt_t MIN_HDR_WORDS = 6'd21;
  localparam cnt_t ETH_TYPE_WORD = 6'd6;
  localparam cnt_t IHL_WORD      = 6'd7;
  localparam cnt_t PROTO_WORD    = 6'd11;
  localparam cnt_t NEED_BASE     = 6'd11;
  localparam cnt_t TYPE_BASE     = 6'd7;

  localparam word_t          ETYPE_IPV4     = 16'h0800;
  localparam logic [7:0]     PROTO_ICMP     = 8'd1;
  localparam logic [7:0]     TYPE_ECHO_REQ  = 8'd8;
  localparam logic [7:0]     TYPE_ECHO_RPL  = 8'd0;
  localparam word_t          CSUM_ADJ       = 16'h0800;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_BURST,
    ST_PASS
  } state_t;

  // Read stage of a header burst
  typedef struct packed {
    logic vld;
    cnt_t k;
    cnt_t t;
    logic reply;
    logic last;
    logic sb;
  } brd_t;

  // Straight-through beat
  typedef struct packed {
    logic  vld;
    word_t word;
    logic  last;
    logic  sb;
    logic  back;
  } pass_t;

  // Word position after MAC and IPv4 address swap
  function automatic addr_t ier_perm(input cnt_t k);
    cnt_t p;
    begin
      case (k)
        6'd0:    p = 6'd3;
        6'd1:    p = 6'd4;
        6'd2:    p = 6'd5;
        6'd3:    p = 6'd0;
        6'd4:    p = 6'd1;
        6'd5:    p = 6'd2;
        6'd13:   p = 6'd15;
        6'd14:   p = 6'd16;
        6'd15:   p = 6'd13;
        6'd16:   p = 6'd14;
        default: p = k;
      endcase
      return addr_t'(p);
    end
  endfunction

endpackage

@@ hw/rtl/ier_ram.sv @@
// ----------------------------------------------------------------------------
// ier_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ier_ram #(
  parameter int DEPTH = 41,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ier_ctrl.sv @@
// ----------------------------------------------------------------------------
// ier_ctrl
// Header capture, verdict and burst read sequencing.
// ----------------------------------------------------------------------------
module ier_ctrl import ier_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  word_t in_frame_word,
  input  logic  in_end_of_frame,
  input  logic  in_single_byte,
  input  logic  adv,
  output logic  ram_we,
  output addr_t ram_waddr,
  output word_t ram_wdata,
  output logic  ram_re,
  output addr_t ram_raddr,
  output brd_t  brd,
  output pass_t pass
);

  state_t st_r, st_nxt;
  cnt_t   idx_r, k_r, last_k_r, need_r, cap_r, t_r;
  logic   eth_ok_r, proto_ok_r, type_ok_r;
  logic   reply_r, fl_last_r, fl_sb_r;
  logic   rd_vld_r, rd_reply_r, rd_last_r, rd_sb_r;
  cnt_t   rd_k_r, rd_t_r;

  logic       acc, issue, collect_acc, release_now, reply_dec, sb_eff, type_hit;
  logic       burst_done;
  cnt_t       n, need_raw, need_v, cap_v, t_v;
  logic [3:0] ihl;

  assign acc         = in_valid & in_ready;
  assign collect_acc = acc && (st_r == ST_COLLECT);
  assign sb_eff      = in_single_byte & in_end_of_frame;
  assign n           = idx_r + 6'd1;

  assign ihl      = in_frame_word[11:8];
  assign need_raw = NEED_BASE + {1'b0, ihl, 1'b0};
  assign need_v   = (need_raw < MIN_HDR_WORDS) ? MIN_HDR_WORDS : need_raw;
  assign cap_v    = (need_v > MAX_N) ? MAX_N : need_v;
  assign t_v      = TYPE_BASE + {1'b0, ihl, 1'b0};

  assign type_hit = ((idx_r == IHL_WORD) && (ihl == 4'd0)) ||
                    ((idx_r > IHL_WORD) && (idx_r == t_r));

  assign release_now = in_end_of_frame || ((idx_r > IHL_WORD) && (n == cap_r));
  assign reply_dec   = (idx_r > IHL_WORD) && (n == need_r) && (need_r <= MAX_N) &&
                       !sb_eff && eth_ok_r && proto_ok_r && type_ok_r;
  assign burst_done  = issue && (k_r == last_k_r);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_COLLECT: begin
        if (collect_acc && release_now) begin
          st_nxt = ST_BURST;
        end
      end
      ST_BURST: begin
        if (burst_done) begin
          st_nxt = fl_last_r ? ST_COLLECT : ST_PASS;
        end
      end
      ST_PASS: begin
        if (acc && in_end_of_frame) begin
          st_nxt = ST_COLLECT;
        end
      end
      default: st_nxt = ST_COLLECT;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    case (st_r)
      ST_COLLECT: in_ready = 1'b1;
      ST_BURST:   issue    = !rd_vld_r || adv;
      ST_PASS:    in_ready = adv && !rd_vld_r;
      default: begin
        in_ready = 1'b0;
        issue    = 1'b0;
      end
    endcase
  end

  assign ram_we    = collect_acc;
  assign ram_waddr = addr_t'(idx_r);
  assign ram_wdata = in_frame_word;
  assign ram_re    = issue;
  assign ram_raddr = reply_r ? ier_perm(k_r) : addr_t'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_COLLECT;
      idx_r    <= '0;
      k_r      <= '0;
      reply_r  <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (collect_acc) begin
        idx_r <= release_now ? '0 : n;
        if (release_now) begin
          reply_r <= reply_dec;
          k_r     <= '0;
        end
      end
      if (issue) begin
        k_r <= k_r + 6'd1;
      end
      if (issue) begin
        rd_vld_r <= 1'b1;
      end else if (adv) begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (collect_acc) begin
      if (idx_r == ETH_TYPE_WORD) begin
        eth_ok_r <= (in_frame_word == ETYPE_IPV4);
      end
      if (idx_r == PROTO_WORD) begin
        proto_ok_r <= (in_frame_word[7:0] == PROTO_ICMP);
      end
      if (idx_r == IHL_WORD) begin
        need_r <= need_v;
        cap_r  <= cap_v;
        t_r    <= t_v;
      end
      if (type_hit) begin
        type_ok_r <= (in_frame_word[15:8] == TYPE_ECHO_REQ);
      end
      if (release_now) begin
        last_k_r  <= idx_r;
        fl_last_r <= in_end_of_frame;
        fl_sb_r   <= sb_eff;
      end
    end
    if (issue) begin
      rd_k_r     <= k_r;
      rd_t_r     <= t_r;
      rd_reply_r <= reply_r;
      rd_last_r  <= (k_r == last_k_r) && fl_last_r;
      rd_sb_r    <= (k_r == last_k_r) && fl_sb_r;
    end
  end

  assign brd.vld   = rd_vld_r;
  assign brd.k     = rd_k_r;
  assign brd.t     = rd_t_r;
  assign brd.reply = rd_reply_r;
  assign brd.last  = rd_last_r;
  assign brd.sb    = rd_sb_r;

  assign pass.vld  = acc && (st_r == ST_PASS);
  assign pass.word = in_frame_word;
  assign pass.last = in_end_of_frame;
  assign pass.sb   = sb_eff;
  assign pass.back = reply_r;

  a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BURST) |-> !in_ready)
    else $error("input taken during header burst");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COLLECT) |-> (idx_r < MAX_N))
    else $error("header index past store depth");

  a_reply_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BURST && reply_r) |-> ((last_k_r + 6'd1) == need_r))
    else $error("reply chosen on short header");

  a_burst_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BURST && burst_done) |=> (st_r != ST_BURST))
    else $error("burst did not end after final read");

endmodule

@@ hw/rtl/ier_out.sv @@
// ----------------------------------------------------------------------------
// ier_out
// Reply edits on header words and the output register.
// ----------------------------------------------------------------------------
module ier_out import ier_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  brd_t  brd,
  input  word_t rdata,
  input  pass_t pass,
  output logic  adv,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_word,
  output logic  out_last,
  output logic  out_single_byte,
  output logic  out_send_back
);

  logic        out_valid_r;
  word_t       out_word_r;
  logic        out_last_r, out_sb_r, out_back_r;
  word_t       edit_word;
  logic [16:0] csum_sum;

  assign adv      = !out_valid_r || out_ready;
  assign csum_sum = {1'b0, rdata} + {1'b0, CSUM_ADJ};

  always_comb begin
    edit_word = rdata;
    if (brd.reply && (brd.k == brd.t)) begin
      edit_word = {TYPE_ECHO_RPL, rdata[7:0]};
    end else if (brd.reply && (brd.k == brd.t + 6'd1)) begin
      edit_word = csum_sum[15:0] + {15'd0, csum_sum[16]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= brd.vld | pass.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (brd.vld) begin
        out_word_r <= edit_word;
        out_last_r <= brd.last;
        out_sb_r   <= brd.sb;
        out_back_r <= brd.reply;
      end else begin
        out_word_r <= pass.word;
        out_last_r <= pass.last;
        out_sb_r   <= pass.sb;
        out_back_r <= pass.back;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_last        = out_last_r;
  assign out_single_byte = out_sb_r;
  assign out_send_back   = out_back_r;

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(brd.vld && pass.vld))
    else $error("burst word and pass beat collide");

  a_sb_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sb_r) |-> out_last_r)
    else $error("single byte flag off the final beat");

endmodule

@@ hw/rtl/icmp_echo_responder_top.sv @@
// Words after the header burst reach out_* in the cycle after acceptance.
// Header words are held until max(21, 11+2*ihl) words (capped at 41) or frame end,
// then released from the header RAM through its read register and the output register;
// 1 word/cycle unless out_ready stalls; input stalls while held header words drain.
// Reset: synchronous, active low; clears control and output valid, not the header RAM.
// ----------------------------------------------------------------------------
// icmp_echo_responder_top
// Turns ICMP echo requests into echo replies on a 16-bit frame word stream.
// ----------------------------------------------------------------------------
module icmp_echo_responder_top import ier_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  word_t in_frame_word,
  input  logic  in_end_of_frame,
  input  logic  in_single_byte,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_word,
  output logic  out_last,
  output logic  out_single_byte,
  output logic  out_send_back
);

  logic  adv, ram_we, ram_re;
  addr_t ram_waddr, ram_raddr;
  word_t ram_wdata, ram_rdata;
  brd_t  brd;
  pass_t pass;

  ier_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frame_word   (in_frame_word),
    .in_end_of_frame (in_end_of_frame),
    .in_single_byte  (in_single_byte),
    .adv             (adv),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .brd             (brd),
    .pass            (pass)
  );

  ier_ram #(
    .DEPTH (MAX_HEADER_WORDS),
    .WIDTH (DATA_W),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ier_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .brd             (brd),
    .rdata           (ram_rdata),
    .pass            (pass),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .out_last        (out_last),
    .out_single_byte (out_single_byte),
    .out_send_back   (out_send_back)
  );

endmodule
